// ----- rtl/goc_pkg.sv -----
package goc_pkg;

  localparam int RATE_W      = 16;
  localparam int SUM_W       = 24;
  localparam int CNT_W       = 8;
  localparam int DB_W        = 15;
  localparam int BYTE_W      = 8;

  // The reciprocal is scaled by 2**31, which keeps the quotient exact for
  // any 24-bit magnitude and any divisor from 2 to 255.
  localparam int DIV_SHIFT   = 31;
  localparam int RECIP_W     = 31;

  localparam int IN_TDATA_W  = 6 * BYTE_W;
  localparam int OUT_TDATA_W = 3 * RATE_W;
  localparam int OUT_TUSER_W = 2;
  localparam int USER_VALID_BIT = 0;
  localparam int USER_CAL_BIT   = 1;

  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int REG_IDX_W   = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_Z_DEADBAND = 1'b0;
  localparam logic [DB_W-1:0]      Z_DEADBAND_RST = 15'd6;

  typedef struct packed {
    logic [RATE_W-1:0] rate_z;
    logic [RATE_W-1:0] rate_y;
    logic [RATE_W-1:0] rate_x;
    logic              read_ok;
  } goc_item_t;

endpackage

// ----- rtl/goc_front.sv -----
module goc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [goc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [0:0]                       in_tuser,
  input  logic [goc_pkg::DB_W-1:0]         z_deadband,
  output logic                             item_valid,
  output goc_pkg::goc_item_t               item,
  input  logic                             item_ready
);

  logic                           vld_r;
  logic [goc_pkg::IN_TDATA_W-1:0] bytes_r;
  logic                           ok_r;

  logic [goc_pkg::RATE_W-1:0] raw_x;
  logic [goc_pkg::RATE_W-1:0] raw_y;
  logic [goc_pkg::RATE_W-1:0] raw_z;
  logic [goc_pkg::RATE_W:0]   z_ext;
  logic [goc_pkg::RATE_W:0]   z_mag;
  logic                       z_dead;

  assign in_tready  = !vld_r || item_ready;
  assign item_valid = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      bytes_r <= in_tdata;
      ok_r    <= in_tuser[0];
    end
  end

  // Each axis arrives high byte first.
  always_comb begin
    raw_x = {bytes_r[7:0],   bytes_r[15:8]};
    raw_y = {bytes_r[23:16], bytes_r[31:24]};
    raw_z = {bytes_r[39:32], bytes_r[47:40]};
    // One extra bit so that the most negative rate has a proper magnitude.
    z_ext  = {raw_z[goc_pkg::RATE_W-1], raw_z};
    z_mag  = z_ext[goc_pkg::RATE_W] ? (~z_ext + 1'b1) : z_ext;
    z_dead = z_mag < {2'b00, z_deadband};

    item.rate_x  = raw_x;
    item.rate_y  = raw_y;
    item.rate_z  = z_dead ? '0 : raw_z;
    item.read_ok = ok_r;
  end

endmodule

// ----- rtl/goc_core.sv -----
module goc_core #(
  parameter int CALIB_SAMPLES = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  input  goc_pkg::goc_item_t                item,
  output logic                              item_ready,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [goc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [goc_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  localparam longint unsigned RECIP_FULL =
    ((64'd1 << goc_pkg::DIV_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam logic [goc_pkg::RECIP_W-1:0] RECIP = goc_pkg::RECIP_W'(RECIP_FULL);
  localparam int PROD_W = goc_pkg::SUM_W + goc_pkg::RECIP_W;

  logic [goc_pkg::SUM_W-1:0]       sum_x_r, sum_y_r, sum_z_r;
  logic [goc_pkg::SUM_W-1:0]       sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic [goc_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            out_vld_r;
  logic [goc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [goc_pkg::OUT_TUSER_W-1:0] out_user_r, out_user_nxt;
  logic                            take;
  logic                            cnt_zero;
  logic                            cnt_one;

  // Signed division by the sample count, truncating toward zero, done as a
  // multiplication of the magnitude by a scaled reciprocal.
  function automatic logic [goc_pkg::SUM_W-1:0] div_by_samples(
    input logic [goc_pkg::SUM_W-1:0] s
  );
    logic [goc_pkg::SUM_W-1:0] mag;
    logic [PROD_W-1:0]         prod;
    logic [goc_pkg::SUM_W-1:0] q;
    mag  = s[goc_pkg::SUM_W-1] ? (~s + 1'b1) : s;
    prod = PROD_W'(mag) * PROD_W'(RECIP);
    q    = prod[goc_pkg::DIV_SHIFT +: goc_pkg::SUM_W];
    return s[goc_pkg::SUM_W-1] ? (~q + 1'b1) : q;
  endfunction

  function automatic logic [goc_pkg::SUM_W-1:0] sext(input logic [goc_pkg::RATE_W-1:0] v);
    return {{(goc_pkg::SUM_W - goc_pkg::RATE_W){v[goc_pkg::RATE_W-1]}}, v};
  endfunction

  assign item_ready = !out_vld_r || out_tready;
  assign take       = item_valid && item_ready;
  assign cnt_zero   = cnt_r == '0;
  assign cnt_one    = cnt_r == goc_pkg::CNT_W'(1);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    sum_z_nxt    = sum_z_r;
    cnt_nxt      = cnt_r;
    out_data_nxt = '0;
    out_user_nxt = '0;
    out_user_nxt[goc_pkg::USER_CAL_BIT] = cnt_zero;
    if (item.read_ok) begin
      out_user_nxt[goc_pkg::USER_VALID_BIT] = 1'b1;
      if (!cnt_zero) begin
        if (cnt_one) begin
          sum_x_nxt = div_by_samples(sum_x_r);
          sum_y_nxt = div_by_samples(sum_y_r);
          sum_z_nxt = div_by_samples(sum_z_r);
        end else begin
          sum_x_nxt = sum_x_r + sext(item.rate_x);
          sum_y_nxt = sum_y_r + sext(item.rate_y);
          sum_z_nxt = sum_z_r + sext(item.rate_z);
        end
        cnt_nxt      = cnt_r - 1'b1;
        out_data_nxt = {item.rate_z, item.rate_y, item.rate_x};
        out_user_nxt[goc_pkg::USER_CAL_BIT] = cnt_one;
      end else begin
        // Only the low half of each offset matters under 16-bit wrap.
        out_data_nxt = {item.rate_z - sum_z_r[goc_pkg::RATE_W-1:0],
                        item.rate_y - sum_y_r[goc_pkg::RATE_W-1:0],
                        item.rate_x - sum_x_r[goc_pkg::RATE_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      sum_z_r   <= '0;
      cnt_r     <= goc_pkg::CNT_W'(CALIB_SAMPLES);
    end else begin
      if (item_ready) begin
        out_vld_r <= item_valid;
      end
      if (take) begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        sum_z_r <= sum_z_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

// ----- rtl/gyro_offset_calibration.sv -----
// A request goes through the input register, then the result register, to the result port.
// Throughput: one request per clock while results are taken. When a result waits, the input
// register takes one more request and the input then stalls until the result is taken.
// Reset (rst_n, synchronous, active low) empties both registers, clears the
// per-axis sums, reloads the calibration countdown and sets the Z deadband to 6.
module gyro_offset_calibration #(
  parameter int CALIB_SAMPLES = 100
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, from bit 0 up: x_high_byte, x_low_byte, y_high_byte,
  // y_low_byte, z_high_byte, z_low_byte
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [goc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: read_ok
  input  logic [0:0]                        in_tuser,
  // out_tdata, from bit 0 up: rate_x, rate_y, rate_z
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [goc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser, from bit 0 up: result_valid, calibrated
  output logic [goc_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [goc_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [goc_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [goc_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [goc_pkg::DB_W-1:0] z_deadband_r;
  logic                     cfg_sel_db;
  logic                     item_valid;
  logic                     item_ready;
  goc_pkg::goc_item_t       item;

  assign cfg_pready = 1'b1;
  assign cfg_sel_db = cfg_paddr[goc_pkg::APB_ADDR_W-1:2] == goc_pkg::REG_Z_DEADBAND;
  assign cfg_prdata = cfg_sel_db ? goc_pkg::APB_DATA_W'(z_deadband_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_deadband_r <= goc_pkg::Z_DEADBAND_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_db) begin
      z_deadband_r <= cfg_pwdata[goc_pkg::DB_W-1:0];
    end
  end

  goc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .z_deadband (z_deadband_r),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  goc_core #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/goc_checker.sv -----
module goc_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tready,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [goc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic [goc_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  // Once calibration is finished it never reverts until the next reset.
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[goc_pkg::USER_CAL_BIT])
      |=> (!out_tvalid || out_tuser[goc_pkg::USER_CAL_BIT]))
    else $error("calibrated flag dropped after calibration");

  // A failed read carries zero rates.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[goc_pkg::USER_VALID_BIT]) |-> (out_tdata == '0))
    else $error("failed read produced non-zero rates");

  // With the result register empty the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled although no result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready)
      |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind gyro_offset_calibration goc_checker u_goc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/goc_checker.sv -----
`timescale 1ns / 100ps

// Watches both streams and the register port, keeps its own copy of the
// calibration state and compares every result against the oldest prediction.
module goc_tb_checker #(
  parameter int CALIB_SAMPLES = 100
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [goc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [goc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [goc_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [goc_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [goc_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  input  logic [goc_pkg::APB_DATA_W-1:0]  cfg_prdata,
  input  logic                            cfg_pready,
  output int                              errors,
  output int                              pending
);

  localparam logic [goc_pkg::APB_ADDR_W-1:0] DB_ADDR = {goc_pkg::REG_Z_DEADBAND, 2'b00};

  typedef struct packed {
    logic [goc_pkg::RATE_W-1:0] rate_x;
    logic [goc_pkg::RATE_W-1:0] rate_y;
    logic [goc_pkg::RATE_W-1:0] rate_z;
    logic                       result_valid;
    logic                       calibrated;
  } rate_result_t;

  rate_result_t                      rates_due[$];
  logic [goc_pkg::DB_W-1:0]          deadband;
  logic signed [goc_pkg::SUM_W-1:0]  sum_x, sum_y, sum_z;
  logic [goc_pkg::CNT_W-1:0]         countdown;

  // The sums collect CALIB_SAMPLES-1 reads and the next good read turns
  // them into offsets; a failed read leaves everything untouched.
  function automatic rate_result_t predict_rates(
    input logic [goc_pkg::IN_TDATA_W-1:0] raw,
    input logic ok
  );
    rate_result_t       r;
    logic signed [15:0] rx, ry, rz;
    int                 mag;
    r = '0;
    if (!ok) begin
      r.calibrated = (countdown == 0);
      return r;
    end
    rx  = {raw[7:0], raw[15:8]};
    ry  = {raw[23:16], raw[31:24]};
    rz  = {raw[39:32], raw[47:40]};
    mag = (rz < 0) ? -int'(rz) : int'(rz);
    if (mag < int'(deadband)) rz = '0;
    if (countdown != 0) begin
      if (countdown == 1) begin
        sum_x = sum_x / CALIB_SAMPLES;
        sum_y = sum_y / CALIB_SAMPLES;
        sum_z = sum_z / CALIB_SAMPLES;
      end else begin
        sum_x = sum_x + rx;
        sum_y = sum_y + ry;
        sum_z = sum_z + rz;
      end
      countdown = countdown - 1'b1;
      r.rate_x  = rx;
      r.rate_y  = ry;
      r.rate_z  = rz;
    end else begin
      r.rate_x = rx - sum_x[15:0];
      r.rate_y = ry - sum_y[15:0];
      r.rate_z = rz - sum_z[15:0];
    end
    r.result_valid = 1'b1;
    r.calibrated   = (countdown == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rate_result_t want;
    if (!rst_n) begin
      errors    = 0;
      deadband  = goc_pkg::Z_DEADBAND_RST;
      sum_x     = '0;
      sum_y     = '0;
      sum_z     = '0;
      countdown = CALIB_SAMPLES[goc_pkg::CNT_W-1:0];
      rates_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == DB_ADDR) begin
        if (cfg_pwrite) begin
          deadband = cfg_pwdata[goc_pkg::DB_W-1:0];
        end else if (cfg_prdata !== goc_pkg::APB_DATA_W'(deadband)) begin
          $error("z_deadband: expected %0d, got %0d", deadband, cfg_prdata);
          errors++;
        end
      end
      // Results are matched before new requests are queued, so a result and
      // a request meeting at one edge never pair up with each other.
      if (out_tvalid && out_tready) begin
        if (rates_due.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = rates_due.pop_front();
          check_field("rate_x", want.rate_x, out_tdata[15:0]);
          check_field("rate_y", want.rate_y, out_tdata[31:16]);
          check_field("rate_z", want.rate_z, out_tdata[47:32]);
          check_field("result_valid", 16'(want.result_valid),
                      16'(out_tuser[goc_pkg::USER_VALID_BIT]));
          check_field("calibrated", 16'(want.calibrated),
                      16'(out_tuser[goc_pkg::USER_CAL_BIT]));
        end
      end
      if (in_tvalid && in_tready) rates_due.push_back(predict_rates(in_tdata, in_tuser[0]));
    end
    pending = rates_due.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int CALIB = 100;
  localparam logic [goc_pkg::APB_ADDR_W-1:0] DB_ADDR = {goc_pkg::REG_Z_DEADBAND, 2'b00};

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [goc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [goc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [goc_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [goc_pkg::APB_ADDR_W-1:0]  cfg_paddr;
  logic [goc_pkg::APB_DATA_W-1:0]  cfg_pwdata;
  logic [goc_pkg::APB_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;
  int                              errors;
  int                              pending;
  int                              stall_cnt = 0;
  bit                              quiet = 1'b0;
  int                              deadband_now;

  gyro_offset_calibration #(.CALIB_SAMPLES(CALIB)) i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  goc_tb_checker #(.CALIB_SAMPLES(CALIB)) i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls between runs of ready cycles, and none once quiet is set.
  always @(negedge clk) begin
    if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
    end else if (!quiet && $urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      stall_cnt  <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
      stall_cnt  <= quiet ? 0 : $urandom_range(0, 19);
    end
  end

  // Rates are big-endian on the bus: the high byte of X sits in bits 7:0.
  function automatic logic [goc_pkg::IN_TDATA_W-1:0] pack_read(input logic [15:0] x,
                                                               input logic [15:0] y,
                                                               input logic [15:0] z);
    return {z[7:0], z[15:8], y[7:0], y[15:8], x[7:0], x[15:8]};
  endfunction

  // Favours the corners of the range and values either side of the deadband.
  function automatic logic [15:0] rand_rate(input int db);
    int          mag;
    logic [15:0] r;
    mag = db + int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0:       r = 16'h8000;
      1:       r = 16'h7FFF;
      2:       r = 16'h0000;
      3:       r = 16'hFFFF;
      4:       r = 16'($urandom_range(0, 20));
      5, 6:    r = 16'((mag < 0) ? 0 : mag);
      default: r = 16'($urandom);
    endcase
    if (mag >= 0 && $urandom_range(0, 1) == 1) r = -r;
    return r;
  endfunction

  task automatic send_read(input logic [goc_pkg::IN_TDATA_W-1:0] raw, input logic ok);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    in_tuser  <= ok;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_reads(input int count, input int db);
    int gap;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_read(goc_pkg::IN_TDATA_W'({$urandom, $urandom}), 1'b0);
      end else begin
        send_read(pack_read(rand_rate(db), rand_rate(db), rand_rate(db)), 1'b1);
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Sampling at the falling edge keeps the count clear of the checker's update.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [goc_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= DB_ADDR;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // The upper write bits are random and must not reach the register.
  task automatic set_deadband(input int value);
    logic [goc_pkg::APB_DATA_W-1:0] word;
    word = $urandom;
    word[goc_pkg::DB_W-1:0] = value[goc_pkg::DB_W-1:0];
    cfg_access(1'b1, word);
    cfg_access(1'b0, '0);
  endtask

  initial begin
    int settings[4];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the deadband, then corner cases while calibrating.
    cfg_access(1'b0, '0);
    send_read(pack_read(16'h0000, 16'h0000, 16'h0000), 1'b1);
    send_read(pack_read(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
    send_read(pack_read(16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b1);
    send_read(pack_read(16'h8000, 16'h8000, 16'h8000), 1'b1);
    send_read(pack_read(16'h00FF, 16'hFF00, 16'h0005), 1'b1);
    send_read(pack_read(16'h1234, 16'hEDCB, 16'h0006), 1'b1);
    send_read(pack_read(16'h0001, 16'h0000, 16'hFFFB), 1'b1);
    send_read(pack_read(16'h0000, 16'h0001, 16'hFFFA), 1'b1);
    send_read(pack_read(16'h0000, 16'h0000, 16'hFFF9), 1'b1);
    send_read(pack_read(16'h0000, 16'h0000, 16'h0007), 1'b1);
    send_read({goc_pkg::IN_TDATA_W{1'b1}}, 1'b0);
    send_read({goc_pkg::IN_TDATA_W{1'b0}}, 1'b0);
    send_read(pack_read(16'h8000, 16'h7FFF, 16'h8001), 1'b0);
    send_random_reads(300, 6);
    drain();

    settings[0] = 0;
    settings[1] = 32767;
    settings[2] = 1;
    settings[3] = $urandom_range(0, 32767);
    for (int p = 0; p < 4; p++) begin
      deadband_now = settings[p];
      set_deadband(deadband_now);
      if (p == 3) quiet = 1'b1;
      send_random_reads(300, deadband_now);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
